[sv/assert_macros.svh]
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while dis is high.
`define MBSS_ASSERT_SAME(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while dis is high.
`define MBSS_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[sv/mbss_pkg.sv]
// Shared types and constants for the masked byte signature scan.
// No dependencies; imported by every RTL module of the block.
`timescale 1ns / 1ps

package mbss_pkg;

  localparam int LOC_W     = 26;
  localparam int DELTA_W   = 16;
  localparam int LEN_W     = 6;
  localparam int ENTRY_W   = 5;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LENGTH = 1'b0,
    CFG_RESULT_DELTA   = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_SCAN = 1'b1
  } cmd_t;

  // Pending scan byte between the window stage and the result stage.
  typedef struct packed {
    logic valid;
    logic last;
  } scan_ctl_t;

  // Outcome of the window compare for the pending byte.
  typedef struct packed {
    logic             hit;
    logic [LOC_W-1:0] location;
  } match_res_t;

endpackage

[sv/mbss_sig_store.sv]
// Signature entry store: mask and value per entry, written by load commands.
// Depends on mbss_pkg.
`timescale 1ns / 1ps

module mbss_sig_store #(
  parameter int PATTERN_MAX = 32
) (
  input  logic                        clk,
  input  logic                        load,
  input  logic [mbss_pkg::ENTRY_W-1:0] entry_index,
  input  logic [7:0]                  entry_mask,
  input  logic [7:0]                  entry_value,
  output logic [7:0]                  sig_masks [PATTERN_MAX],
  output logic [7:0]                  sig_values [PATTERN_MAX]
);
  import mbss_pkg::*;

  localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  logic          in_range;
  logic [IW-1:0] wr_idx;

  assign in_range = 32'(entry_index) < PATTERN_MAX;
  assign wr_idx   = IW'(entry_index);

  // Drop loads to entries beyond the store.
  always_ff @(posedge clk) begin
    if (load && in_range) begin
      sig_masks[wr_idx]  <= entry_mask;
      sig_values[wr_idx] <= entry_value;
    end
  end

endmodule

[sv/mbss_front.sv]
// Window stage: byte shift window, buffer position count and the pending
// scan byte handed to the compare. Depends on mbss_pkg.
`timescale 1ns / 1ps

module mbss_front #(
  parameter int PATTERN_MAX   = 32,
  parameter int POSITION_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     scan_take,
  input  logic                     advance,
  input  logic [7:0]               data_byte,
  input  logic                     last_byte,
  output logic [7:0]               window [PATTERN_MAX],
  output logic [POSITION_BITS-1:0] pos,
  output mbss_pkg::scan_ctl_t      pend
);
  import mbss_pkg::*;

  logic [POSITION_BITS-1:0] bytes_seen;

  always_ff @(posedge clk) begin
    if (scan_take) begin
      window[0] <= data_byte;
      for (int k = 1; k < PATTERN_MAX; k++) begin
        window[k] <= window[k-1];
      end
      pos <= bytes_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      pend       <= '0;
    end else begin
      if (scan_take) begin
        // Restart the count after the buffer's last byte; saturate otherwise.
        if (last_byte) begin
          bytes_seen <= '0;
        end else if (bytes_seen != '1) begin
          bytes_seen <= bytes_seen + POSITION_BITS'(1);
        end
        pend.valid <= 1'b1;
        pend.last  <= last_byte;
      end else if (advance) begin
        pend.valid <= 1'b0;
      end
    end
  end

endmodule

[sv/mbss_match.sv]
// Parallel window compare and location arithmetic for the pending byte.
// Depends on mbss_pkg.
`timescale 1ns / 1ps

module mbss_match #(
  parameter int PATTERN_MAX   = 32,
  parameter int POSITION_BITS = 24
) (
  input  logic [7:0]                      window [PATTERN_MAX],
  input  logic [7:0]                      sig_masks [PATTERN_MAX],
  input  logic [7:0]                      sig_values [PATTERN_MAX],
  input  logic [mbss_pkg::LEN_W-1:0]      pattern_length,
  input  logic signed [mbss_pkg::DELTA_W-1:0] result_delta,
  input  logic [POSITION_BITS-1:0]        pos,
  output mbss_pkg::match_res_t            res
);
  import mbss_pkg::*;

  localparam int IW  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LW  = $clog2(PATTERN_MAX + 1) > 0 ? $clog2(PATTERN_MAX + 1) : 1;
  localparam int AW  = (POSITION_BITS > LOC_W) ? POSITION_BITS : LOC_W;
  localparam int PW1 = POSITION_BITS + 1;

  logic [LW-1:0]          len;
  logic [PATTERN_MAX-1:0] lane_ok;
  logic                   reach;
  logic [AW-1:0]          start;
  logic [AW-1:0]          loc_full;

  // Saturate the length at the store depth.
  assign len = (32'(pattern_length) > PATTERN_MAX) ? LW'(PATTERN_MAX)
                                                   : LW'(pattern_length);

  // Entry j lines up with the byte len-1-j positions before the newest one.
  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_lane
    logic [LW-1:0] sel;
    assign sel        = len - LW'(j + 1);
    assign lane_ok[j] = (LW'(j) >= len) ||
                        ((window[sel[IW-1:0]] & sig_masks[j]) == sig_values[j]);
  end

  assign reach = (PW1'(pos) + PW1'(1)) >= PW1'(len);

  assign start    = (len == '0) ? AW'(pos) : AW'(pos) + AW'(1) - AW'(len);
  assign loc_full = start + AW'(result_delta);

  assign res.hit      = reach && (&lane_ok);
  assign res.location = loc_full[LOC_W-1:0];

endmodule

[sv/masked_byte_signature_scan_top.sv]
// Masked byte signature scan: one stream byte or load per cycle while the result
// side keeps taking transfers; an accepted scan byte enters the window and the
// pending-byte register, the window compare sits between that register and the
// result register, and the result is presented from the result register.
// Synchronous active-high reset: pattern_length 1, result_delta 0, buffer
// position and match flag cleared; signature entries stay unknown until loaded.
`timescale 1ns / 1ps

module masked_byte_signature_scan_top #(
  parameter int PATTERN_MAX   = 32,
  parameter int POSITION_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic                              command,
  input  logic [mbss_pkg::ENTRY_W-1:0]      entry_index,
  input  logic [7:0]                        entry_mask,
  input  logic [7:0]                        entry_value,
  input  logic [7:0]                        data_byte,
  input  logic                              last_byte,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic                              found,
  output logic signed [mbss_pkg::LOC_W-1:0] location,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mbss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mbss_pkg::DELTA_W-1:0]      cfg_data
);
  import mbss_pkg::*;

  logic [LEN_W-1:0]          pattern_length;
  logic signed [DELTA_W-1:0] result_delta;
  logic                      scan_done;

  logic                      take;
  logic                      scan_take;
  logic                      load;
  logic                      out_free;
  logic                      advance;
  logic                      emit;
  logic                      emit_found;

  logic [7:0]                window [PATTERN_MAX];
  logic [7:0]                sig_masks [PATTERN_MAX];
  logic [7:0]                sig_values [PATTERN_MAX];
  logic [POSITION_BITS-1:0]  pos;
  scan_ctl_t                 pend;
  match_res_t                res;

  assign out_free   = !result_valid || !result_stall;
  assign advance    = pend.valid && out_free;
  assign item_stall = pend.valid && !out_free;
  assign take       = item_valid && !item_stall;
  assign scan_take  = take && (command == CMD_SCAN);
  assign load       = take && (command == CMD_LOAD);
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= LEN_W'(1);
      result_delta   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        CFG_RESULT_DELTA:   result_delta   <= cfg_data;
        default: ;
      endcase
    end
  end

  mbss_sig_store #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_sig (
    .clk        (clk),
    .load       (load),
    .entry_index(entry_index),
    .entry_mask (entry_mask),
    .entry_value(entry_value),
    .sig_masks  (sig_masks),
    .sig_values (sig_values)
  );

  mbss_front #(
    .PATTERN_MAX  (PATTERN_MAX),
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .scan_take(scan_take),
    .advance  (advance),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .window   (window),
    .pos      (pos),
    .pend     (pend)
  );

  mbss_match #(
    .PATTERN_MAX  (PATTERN_MAX),
    .POSITION_BITS(POSITION_BITS)
  ) u_match (
    .window        (window),
    .sig_masks     (sig_masks),
    .sig_values    (sig_values),
    .pattern_length(pattern_length),
    .result_delta  (result_delta),
    .pos           (pos),
    .res           (res)
  );

  // Report the first hit of a buffer, or a miss at its last byte.
  assign emit_found = !scan_done && res.hit;
  assign emit       = emit_found || (!scan_done && pend.last);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_done    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (advance) begin
        result_valid <= emit;
        if (pend.last) begin
          scan_done <= 1'b0;
        end else if (emit_found) begin
          scan_done <= 1'b1;
        end
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      found    <= emit_found;
      location <= emit_found ? res.location : '0;
    end
  end

endmodule

[sv/mbss_checker.sv]
// Port-level checks for the masked byte signature scan, bound to the top.
// Depends on assert_macros.svh and mbss_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mbss_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              item_stall,
  input logic                              result_valid,
  input logic                              result_stall,
  input logic                              found,
  input logic signed [mbss_pkg::LOC_W-1:0] location,
  input logic                              cfg_valid,
  input logic                              cfg_ready
);

  // A stalled result holds until the transfer.
  `MBSS_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(found) && $stable(location))

  // A miss always reports location zero.
  `MBSS_ASSERT_SAME(a_miss_zero, clk, rst, result_valid && !found, location == '0)

  // Nothing is presented right after reset.
  `MBSS_ASSERT_SAME(a_reset_empty, clk, 1'b0, $past(rst), !result_valid)

  // The input side stalls only while a result is waiting to be taken.
  `MBSS_ASSERT_SAME(a_stall_cause, clk, rst, item_stall, result_valid && result_stall)

  // Register writes are never held off.
  `MBSS_ASSERT_SAME(a_cfg_ready, clk, rst, cfg_valid, cfg_ready)

endmodule

bind masked_byte_signature_scan_top mbss_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .item_stall  (item_stall),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .found       (found),
  .location    (location),
  .cfg_valid   (cfg_valid),
  .cfg_ready   (cfg_ready)
);

[tb/mbss_scan_scoreboard.sv]
// Scoreboard for the masked byte signature scan testbench: the item type, a
// predictor of the scan reports and the queue of reports still expected.
// Depends on mbss_pkg.
`timescale 1ns / 1ps

package mbss_tb_pkg;
  import mbss_pkg::*;

  localparam int SIG_DEPTH = 32;
  localparam int POS_W     = 24;

  typedef struct {
    cmd_t               command;
    logic [ENTRY_W-1:0] index;
    logic [7:0]         mask;
    logic [7:0]         value;
    logic [7:0]         data;
    logic               last;
  } scan_item_t;

  typedef struct {
    logic             found;
    logic [LOC_W-1:0] location;
  } scan_report_t;

  class match_scoreboard;
    logic [7:0]                sig_mask [SIG_DEPTH];
    logic [7:0]                sig_value [SIG_DEPTH];
    logic [7:0]                window [SIG_DEPTH];
    logic [POS_W-1:0]          seen;
    logic                      matched;
    logic [LEN_W-1:0]          pattern_len;
    logic signed [DELTA_W-1:0] delta;
    scan_report_t              expected_reports [$];
    int                        errors;
    int                        hits;
    int                        misses;
    int                        loads;
    int                        scans;

    function new();
      foreach (window[k]) begin
        window[k]    = '0;
        sig_mask[k]  = '0;
        sig_value[k] = '0;
      end
      seen        = '0;
      matched     = 1'b0;
      pattern_len = LEN_W'(1);
      delta       = '0;
      errors      = 0;
      hits        = 0;
      misses      = 0;
      loads       = 0;
      scans       = 0;
    endfunction

    function void set_register(cfg_reg_t idx, logic [DELTA_W-1:0] data);
      case (idx)
        CFG_PATTERN_LENGTH: pattern_len = data[LEN_W-1:0];
        CFG_RESULT_DELTA:   delta = data;
        default: ;
      endcase
    endfunction

    function void take_item(scan_item_t it);
      int   pos;
      int   len;
      int   start;
      int   k;
      logic hit;
      if (it.command == CMD_LOAD) begin
        sig_mask[it.index]  = it.mask;
        sig_value[it.index] = it.value;
        loads++;
        return;
      end
      scans++;
      pos = int'(seen);
      for (k = SIG_DEPTH - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = it.data;
      if (seen != '1) seen++;
      if (matched) begin
        // ignore the rest of the buffer
        if (it.last) begin
          seen    = '0;
          matched = 1'b0;
        end
        return;
      end
      len = (pattern_len > SIG_DEPTH) ? SIG_DEPTH : int'(pattern_len);
      // entry 0 lines up with the oldest of the last len bytes of the window
      hit = (pos + 1 >= len);
      for (k = 0; k < len; k++)
        if ((window[len-1-k] & sig_mask[k]) != sig_value[k]) hit = 1'b0;
      if (hit) begin
        start = (len == 0) ? pos : pos + 1 - len;
        expected_reports.push_back('{1'b1, LOC_W'(start + int'(delta))});
        hits++;
        matched = 1'b1;
      end else if (it.last) begin
        expected_reports.push_back('{1'b0, '0});
        misses++;
      end
      if (it.last) begin
        seen    = '0;
        matched = 1'b0;
      end
    endfunction

    function void check_report(logic found, logic [LOC_W-1:0] location);
      scan_report_t want;
      if (expected_reports.size() == 0) begin
        $error("report with none expected: found=%0b location=%h", found, location);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      if (found !== want.found) begin
        $error("found: expected %0b, got %0b", want.found, found);
        errors++;
      end
      if (location !== want.location) begin
        $error("location: expected %h, got %h", want.location, location);
        errors++;
      end
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction
  endclass

endpackage

[tb/masked_byte_signature_scan_top_test.sv]
// Testbench top for masked_byte_signature_scan_top: directed and random load and
// scan traffic with random idling on both sides, checked against the scoreboard.
// Depends on mbss_pkg, mbss_tb_pkg and the block's RTL.
`timescale 1ns / 1ps

module masked_byte_signature_scan_top_test;
  import mbss_pkg::*;
  import mbss_tb_pkg::*;

  localparam int RANDOM_ITEMS = 620;
  localparam int IDLE_PCT     = 28;
  localparam int DRAIN_CYCLES = 6;
  localparam int LONG_HOLD    = 90;
  localparam int STUCK_LIMIT  = 2000;

  logic                 clk;
  logic                 rst;
  logic                 item_valid;
  logic                 item_stall;
  logic                 command;
  logic [ENTRY_W-1:0]   entry_index;
  logic [7:0]           entry_mask;
  logic [7:0]           entry_value;
  logic [7:0]           data_byte;
  logic                 last_byte;
  logic                 result_valid;
  logic                 result_stall;
  logic                 found;
  logic signed [LOC_W-1:0] location;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DELTA_W-1:0]   cfg_data;

  match_scoreboard sb;
  int              idle_pct;
  bit              hold_req;
  int              stuck_cycles;
  int              n_items;
  int              n_cfg;
  logic [7:0]      cur_mask [SIG_DEPTH];
  logic [7:0]      cur_value [SIG_DEPTH];

  masked_byte_signature_scan_top DUT (.*);

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Result side: random stall, or a long hold-off when requested.
  initial begin
    int hold_left;
    hold_left    = 0;
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= ($urandom_range(99) < idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && !result_stall) sb.check_report(found, location);
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", stuck_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Hold valid and payload until the transfer happens.
  task automatic send(scan_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid  <= 1'b1;
    command     <= it.command;
    entry_index <= it.index;
    entry_mask  <= it.mask;
    entry_value <= it.value;
    data_byte   <= it.data;
    last_byte   <= it.last;
    do @(posedge clk); while (item_stall);
    sb.take_item(it);
    n_items++;
  endtask

  task automatic load_entry(int idx, logic [7:0] m, logic [7:0] v);
    scan_item_t it;
    it.command = CMD_LOAD;
    it.index   = ENTRY_W'(idx);
    it.mask    = m;
    it.value   = v;
    it.data    = 8'($urandom);
    it.last    = 1'($urandom);
    cur_mask[idx]  = m;
    cur_value[idx] = v;
    send(it);
  endtask

  task automatic scan_byte(logic [7:0] b, logic last);
    scan_item_t it;
    it.command = CMD_SCAN;
    it.index   = ENTRY_W'($urandom);
    it.mask    = 8'($urandom);
    it.value   = 8'($urandom);
    it.data    = b;
    it.last    = last;
    send(it);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // a trailing load or silent byte may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reconfigure(logic [DELTA_W-1:0] len_word, logic [DELTA_W-1:0] delta_word);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_PATTERN_LENGTH;
    cfg_data  <= len_word;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(CFG_PATTERN_LENGTH, len_word);
    cfg_index <= CFG_RESULT_DELTA;
    cfg_data  <= delta_word;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(CFG_RESULT_DELTA, delta_word);
    cfg_valid <= 1'b0;
    n_cfg += 2;
  endtask

  function automatic logic [7:0] rand_mask();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 8'h00;
    if (r < 30) return 8'hFF;
    return 8'($urandom);
  endfunction

  initial begin
    int         base;
    int         len;
    int         leff;
    int         nbytes;
    int         plant_at;
    int         roll;
    int         k;
    bit         held;
    logic [7:0] m;
    logic [7:0] stream [64];
    sb          = new();
    idle_pct    = IDLE_PCT;
    held        = 1'b0;
    len         = 1;
    rst         = 1'b1;
    item_valid  = 1'b0;
    command     = CMD_LOAD;
    entry_index = '0;
    entry_mask  = '0;
    entry_value = '0;
    data_byte   = '0;
    last_byte   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_PATTERN_LENGTH;
    cfg_data    = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Program every entry so no compare ever reads an unwritten one.
    for (k = 0; k < SIG_DEPTH; k++) load_entry(k, 8'hFF, 8'(k));

    // Directed: length 1 after reset, match, ignored tail, miss at buffer end.
    load_entry(0, 8'hFF, 8'hFF);
    load_entry(SIG_DEPTH - 1, 8'h00, 8'h00);
    load_entry(1, 8'h0F, 8'h05);
    scan_byte(8'h00, 1'b0);
    scan_byte(8'hFF, 1'b0);
    scan_byte(8'hFF, 1'b1);
    scan_byte(8'h12, 1'b1);
    // most negative delta; a buffer that ends before the window fills
    reconfigure(16'd2, 16'h8000);
    scan_byte(8'hFF, 1'b0);
    scan_byte(8'hA5, 1'b0);
    scan_byte(8'h00, 1'b1);
    scan_byte(8'hFF, 1'b1);
    // empty signature matches on the first byte
    reconfigure(16'd0, 16'h7FFF);
    scan_byte(8'h55, 1'b0);
    scan_byte(8'hAA, 1'b1);
    // oversized length saturates; match completes on the last byte
    reconfigure(16'd63, 16'h0000);
    for (k = 0; k < SIG_DEPTH; k++)
      scan_byte((k == 0) ? 8'hFF : (k == 1) ? 8'hA5 :
                (k == SIG_DEPTH - 1) ? 8'($urandom) : 8'(k), k == SIG_DEPTH - 1);
    // load in the middle of a buffer applies from the next byte
    reconfigure(16'd1, 16'h0001);
    scan_byte(8'h00, 1'b0);
    load_entry(0, 8'h00, 8'h00);
    scan_byte(8'h37, 1'b0);
    scan_byte(8'h00, 1'b1);

    base = n_items;
    while (n_items - base < RANDOM_ITEMS) begin
      idle_pct = (n_items - base >= 350 && n_items - base < 500) ? 0 : IDLE_PCT;
      if (!held && n_items - base >= 200) begin
        // one-byte buffers each yield a report, so the block backs up
        hold_req = 1'b1;
        repeat (40) scan_byte(8'($urandom), 1'b1);
        held = 1'b1;
      end
      roll = $urandom_range(99);
      if (roll < 8) begin
        repeat (12) begin
          if ($urandom_range(3) == 0)
            load_entry($urandom_range(SIG_DEPTH - 1), 8'($urandom), 8'($urandom));
          else
            scan_byte(8'($urandom), $urandom_range(4) == 0);
        end
      end else begin
        if (roll < 45) begin
          k = $urandom_range(99);
          if (k < 5) len = 0;
          else if (k < 10) len = $urandom_range(33, 63);
          else if (k < 30) len = $urandom_range(7, 32);
          else len = $urandom_range(1, 6);
          reconfigure({10'($urandom), 6'(len)}, 16'($urandom));
        end
        leff = (len > SIG_DEPTH) ? SIG_DEPTH : len;
        if (roll < 45 || $urandom_range(1) == 0) begin
          for (k = 0; k < leff; k++) begin
            m = rand_mask();
            load_entry(k, m, ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom) & m);
          end
        end
        nbytes = ($urandom_range(9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, leff + 8);
        for (k = 0; k < nbytes; k++) stream[k] = 8'($urandom);
        if (nbytes >= leff && $urandom_range(99) < 75) begin
          plant_at = $urandom_range(nbytes - leff);
          for (k = 0; k < leff; k++)
            stream[plant_at + k] = (cur_value[k] & cur_mask[k]) | (8'($urandom) & ~cur_mask[k]);
        end
        for (k = 0; k < nbytes; k++) begin
          if ($urandom_range(99) < 3) begin
            m = rand_mask();
            load_entry($urandom_range(SIG_DEPTH - 1), m, 8'($urandom) & m);
          end
          scan_byte(stream[k], k == nbytes - 1);
        end
      end
    end

    drain();
    $display("Sent %0d items (%0d loads, %0d stream bytes) over %0d register writes.",
             n_items, sb.loads, sb.scans, n_cfg);
    $display("Checked %0d match reports and %0d buffers that ended without a match.",
             sb.hits, sb.misses);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
